// File: src/mrwt_pkg.sv
package mrwt_pkg;

    localparam int NUMBER_WIDTH = 31;
    localparam int BIT_IDX_W    = $clog2(NUMBER_WIDTH);
    localparam int SHIFT_W      = $clog2(NUMBER_WIDTH + 1);

    localparam logic [1:0] VERDICT_PRIME     = 2'd0;
    localparam logic [1:0] VERDICT_COMPOSITE = 2'd1;
    localparam logic [1:0] VERDICT_INVALID   = 2'd2;

    // Controller to datapath commands
    typedef struct packed {
        logic load;       // capture operands, u = n-1, clear t
        logic split_step; // shift u right by one, count t
        logic init_pow;   // d = 1, bit index to top
        logic mul_start;  // start modular multiply
        logic mul_sel_a;  // 0: d*d, 1: d*a
        logic mul_wb;     // write product to d
        logic bit_dec;    // next exponent bit
        logic sq_wb;      // write squaring product, advance square count
    } mrwt_cmd_t;

    // Datapath to controller status
    typedef struct packed {
        logic invalid;
        logic u_odd;
        logic mul_done;
        logic exp_bit;
        logic bit_last;
        logic sq_left;     // squarings remain
        logic nontrivial;  // product is 1 and root is not +-1
        logic d_is_one;
    } mrwt_stat_t;

endpackage

// File: src/miller_rabin_witness_test.sv
// Miller-Rabin witness test, one round per beat.
// A valid item (n-1 = u*2^t) runs the split, the exponentiation and up to t squarings;
// an invalid item is answered right after the check.
// Items are handled one at a time; a new item is taken only once the controller is back
// in idle, after the result is issued. Each shift-add modular product sets the rate.
// Reset: rst_n asynchronous, active low; clears the controller and output valid.
module miller_rabin_witness_test
    import mrwt_pkg::*;
(
    input  logic                    clk,
    input  logic                    rst_n,
    input  logic                    in_valid,
    output logic                    in_stall,
    input  logic [NUMBER_WIDTH-1:0] candidate,
    input  logic [NUMBER_WIDTH-1:0] base,
    output logic                    out_valid,
    input  logic                    out_stall,
    output logic [1:0]              verdict
);

    mrwt_cmd_t  cmd;
    mrwt_stat_t stat;
    logic [1:0] verdict_int;

    mrwt_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_stall  (in_stall),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .verdict   (verdict_int),
        .cmd       (cmd),
        .stat      (stat)
    );

    mrwt_datapath u_datapath (
        .clk       (clk),
        .rst_n     (rst_n),
        .candidate (candidate),
        .base      (base),
        .cmd       (cmd),
        .stat      (stat)
    );

    assign verdict = verdict_int;

endmodule

// File: src/mrwt_modmul.sv
module mrwt_modmul
    import mrwt_pkg::*;
(
    input  logic                    clk,
    input  logic                    rst_n,
    input  logic                    start,
    input  logic [NUMBER_WIDTH-1:0] x,
    input  logic [NUMBER_WIDTH-1:0] y,
    input  logic [NUMBER_WIDTH-1:0] n,
    output logic                    done,
    output logic [NUMBER_WIDTH-1:0] product
);

    logic                    busy_reg;
    logic [BIT_IDX_W-1:0]    idx_reg;
    logic [NUMBER_WIDTH-1:0] acc_reg, acc_next;
    logic [NUMBER_WIDTH-1:0] x_reg, y_reg;
    logic                    done_reg;
    logic [NUMBER_WIDTH:0]   dbl, dbl_red, sum;

    // Double, reduce, then conditionally add x and reduce
    always_comb
    begin
        dbl     = {acc_reg, 1'b0};
        dbl_red = (dbl >= {1'b0, n}) ? dbl - {1'b0, n} : dbl;
        sum     = dbl_red + (y_reg[idx_reg] ? {1'b0, x_reg} : '0);
        if (sum >= {1'b0, n})
            sum = sum - {1'b0, n};
        acc_next = sum[NUMBER_WIDTH-1:0];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            idx_reg  <= '0;
        end
        else
        begin
            done_reg <= 1'b0;
            if (start)
            begin
                busy_reg <= 1'b1;
                idx_reg  <= BIT_IDX_W'(NUMBER_WIDTH - 1);
            end
            else if (busy_reg)
            begin
                if (idx_reg == '0)
                begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
                else
                    idx_reg <= idx_reg - 1'b1;
            end
        end
    end

    // Operands and accumulator
    always_ff @(posedge clk)
    begin
        if (start)
        begin
            x_reg   <= x;
            y_reg   <= y;
            acc_reg <= '0;
        end
        else if (busy_reg)
            acc_reg <= acc_next;
    end

    assign done    = done_reg;
    assign product = acc_reg;

endmodule

// File: src/mrwt_datapath.sv
module mrwt_datapath
    import mrwt_pkg::*;
(
    input  logic                    clk,
    input  logic                    rst_n,
    input  logic [NUMBER_WIDTH-1:0] candidate,
    input  logic [NUMBER_WIDTH-1:0] base,
    input  mrwt_cmd_t               cmd,
    output mrwt_stat_t              stat
);

    logic [NUMBER_WIDTH-1:0] n_reg, a_reg, u_reg, d_reg;
    logic [SHIFT_W-1:0]      t_reg;
    logic [BIT_IDX_W-1:0]    bit_reg;
    logic [NUMBER_WIDTH-1:0] mul_y, product;
    logic                    mul_done;
    logic [NUMBER_WIDTH-1:0] one;

    assign one   = NUMBER_WIDTH'(1);
    assign mul_y = cmd.mul_sel_a ? a_reg : d_reg;

    mrwt_modmul u_modmul (
        .clk     (clk),
        .rst_n   (rst_n),
        .start   (cmd.mul_start),
        .x       (d_reg),
        .y       (mul_y),
        .n       (n_reg),
        .done    (mul_done),
        .product (product)
    );

    // Operand, exponent and accumulator registers
    always_ff @(posedge clk)
    begin
        if (cmd.load)
        begin
            n_reg <= candidate;
            a_reg <= base;
            u_reg <= candidate - one;
            t_reg <= '0;
        end
        else if (cmd.split_step)
        begin
            u_reg <= u_reg >> 1;
            t_reg <= t_reg + 1'b1;
        end
        if (cmd.init_pow)
        begin
            d_reg   <= one;
            bit_reg <= BIT_IDX_W'(NUMBER_WIDTH - 1);
        end
        else
        begin
            if (cmd.mul_wb)
                d_reg <= product;
            if (cmd.bit_dec)
                bit_reg <= bit_reg - 1'b1;
            if (cmd.sq_wb)
            begin
                d_reg <= product;
                t_reg <= t_reg - 1'b1;
            end
        end
    end

    // Status back to the controller
    always_comb
    begin
        stat.invalid    = (n_reg < NUMBER_WIDTH'(3)) || (a_reg == '0) || (a_reg >= n_reg);
        stat.u_odd      = u_reg[0];
        stat.mul_done   = mul_done;
        stat.exp_bit    = u_reg[bit_reg];
        stat.bit_last   = (bit_reg == '0);
        stat.sq_left    = (t_reg != '0);
        stat.nontrivial = (product == one) && (d_reg != one) && (d_reg != n_reg - one);
        stat.d_is_one   = (d_reg == one);
    end

endmodule

// File: src/mrwt_ctrl.sv
module mrwt_ctrl
    import mrwt_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       in_valid,
    output logic       in_stall,
    output logic       out_valid,
    input  logic       out_stall,
    output logic [1:0] verdict,
    output mrwt_cmd_t  cmd,
    input  mrwt_stat_t stat
);

    typedef enum logic [3:0] {
        S_IDLE, S_CHECK, S_SPLIT, S_SQ_GO, S_SQ_WAIT, S_MUL_GO, S_MUL_WAIT,
        S_NEXT_BIT, S_R_GO, S_R_WAIT, S_DONE
    } state_t;

    state_t     state_reg, state_next;
    logic       out_valid_reg, out_valid_next;
    logic [1:0] verdict_reg, verdict_next;
    logic [1:0] pend_reg, pend_next;
    logic       finish;

    assign in_stall  = (state_reg != S_IDLE);
    assign out_valid = out_valid_reg;
    assign verdict   = verdict_reg;

    // Sequence check, split, exponentiation, squarings and result issue
    always_comb
    begin
        cmd            = '0;
        state_next     = state_reg;
        out_valid_next = out_valid_reg;
        verdict_next   = verdict_reg;
        pend_next      = pend_reg;
        finish         = 1'b0;
        if (out_valid_reg && !out_stall)
            out_valid_next = 1'b0;
        case (state_reg)
            S_IDLE:
                if (in_valid)
                begin
                    cmd.load   = 1'b1;
                    state_next = S_CHECK;
                end
            S_CHECK:
                if (stat.invalid)
                begin
                    pend_next = VERDICT_INVALID;
                    finish    = 1'b1;
                end
                else
                    state_next = S_SPLIT;
            S_SPLIT:
                if (stat.u_odd)
                begin
                    cmd.init_pow = 1'b1;
                    state_next   = S_SQ_GO;
                end
                else
                    cmd.split_step = 1'b1;
            S_SQ_GO:
            begin
                cmd.mul_start = 1'b1;
                state_next    = S_SQ_WAIT;
            end
            S_SQ_WAIT:
                if (stat.mul_done)
                begin
                    cmd.mul_wb = 1'b1;
                    state_next = stat.exp_bit ? S_MUL_GO : S_NEXT_BIT;
                end
            S_MUL_GO:
            begin
                cmd.mul_start = 1'b1;
                cmd.mul_sel_a = 1'b1;
                state_next    = S_MUL_WAIT;
            end
            S_MUL_WAIT:
            begin
                cmd.mul_sel_a = 1'b1;
                if (stat.mul_done)
                begin
                    cmd.mul_wb = 1'b1;
                    state_next = S_NEXT_BIT;
                end
            end
            S_NEXT_BIT:
                if (stat.bit_last)
                    state_next = S_R_GO;
                else
                begin
                    cmd.bit_dec = 1'b1;
                    state_next  = S_SQ_GO;
                end
            S_R_GO:
                if (stat.sq_left)
                begin
                    cmd.mul_start = 1'b1;
                    state_next    = S_R_WAIT;
                end
                else
                begin
                    pend_next = stat.d_is_one ? VERDICT_PRIME : VERDICT_COMPOSITE;
                    finish    = 1'b1;
                end
            S_R_WAIT:
                if (stat.mul_done)
                begin
                    if (stat.nontrivial)
                    begin
                        pend_next = VERDICT_COMPOSITE;
                        finish    = 1'b1;
                    end
                    else
                    begin
                        cmd.sq_wb  = 1'b1;
                        state_next = S_R_GO;
                    end
                end
            S_DONE:
                // Issue the held verdict once the output register is free
                if (!out_valid_reg || !out_stall)
                begin
                    out_valid_next = 1'b1;
                    verdict_next   = pend_reg;
                    state_next     = S_IDLE;
                end
            default:
                state_next = S_IDLE;
        endcase
        if (finish)
            state_next = S_DONE;
    end

    // Hold state and the result beat
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            out_valid_reg <= 1'b0;
            verdict_reg   <= VERDICT_PRIME;
            pend_reg      <= VERDICT_PRIME;
        end
        else
        begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
            verdict_reg   <= verdict_next;
            pend_reg      <= pend_next;
        end
    end

endmodule

// File: src/mrwt_checker.sv
module mrwt_checker
    import mrwt_pkg::*;
(
    input logic       clk,
    input logic       rst_n,
    input logic       in_valid,
    input logic       in_stall,
    input logic       out_valid,
    input logic       out_stall,
    input logic [1:0] verdict
);

    // Verdict is never the unused code
    a_code: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> (verdict != 2'd3))
        else $error("verdict code out of range");

    // Stalled beat holds
    a_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_stall |=> out_valid && $stable(verdict))
        else $error("stalled result changed");

    // No new item taken the cycle after one is taken
    a_busy: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && !in_stall |=> in_stall)
        else $error("input accepted while busy");

    // A result cannot appear the cycle right after acceptance
    a_lat: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && !in_stall && !out_valid |=> !out_valid)
        else $error("result too early");

endmodule

bind miller_rabin_witness_test mrwt_checker u_mrwt_checker (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .verdict   (verdict)
);
